// ===== rtl/core/grc_pkg.sv =====
package grc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_N_W = 43;
    localparam int DIV_D_W = 24;
    localparam int DIV_CNT_W = 6;
    localparam logic [23:0] SAT24 = 24'hFFFFFF;
    localparam logic [17:0] HIT_MAX = 18'h3FFFF;

    typedef enum logic [2:0] {
        CFG_MAP_BITS   = 3'd0,
        CFG_MAP_WIDTH  = 3'd1,
        CFG_MAP_HEIGHT = 3'd2,
        CFG_CELL_LOG2  = 3'd3,
        CFG_MAX_DIST   = 3'd4,
        CFG_WIN_H      = 3'd5,
        CFG_COL_W      = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVX,
        ST_WDX,
        ST_DIVY,
        ST_WDY,
        ST_MULX,
        ST_MULY,
        ST_SETY,
        ST_WALK,
        ST_DIVH,
        ST_WDH,
        ST_HITX,
        ST_HITY,
        ST_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_X,
        OP_DIV_Y,
        OP_DIV_H,
        OP_LATCH_DX,
        OP_LATCH_DY,
        OP_MUL_LX,
        OP_MUL_LY,
        OP_SET_LY,
        OP_STEP,
        OP_LATCH_H,
        OP_MUL_HX,
        OP_MUL_HY,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic div_done;
        logic walk_done;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/grc_if.sv =====
interface grc_ray_if;
    logic               valid;
    logic               ready;
    logic [17:0]        pos_x;
    logic [17:0]        pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [7:0]         ray_index;

    modport source(output valid, pos_x, pos_y, dir_x, dir_y, ray_index, input ready);
    modport sink(input valid, pos_x, pos_y, dir_x, dir_y, ray_index, output ready);
endinterface

interface grc_res_if;
    logic              valid;
    logic              ready;
    logic [7:0]        ray_number;
    logic              hit;
    logic              side;
    logic signed [8:0] cell_x;
    logic signed [8:0] cell_y;
    logic [23:0]       ray_distance;
    logic [17:0]       hit_x;
    logic [17:0]       hit_y;
    logic [10:0]       draw_start;
    logic [10:0]       draw_end;
    logic [15:0]       column_x_start;

    modport source(output valid, ray_number, hit, side, cell_x, cell_y, ray_distance,
                   hit_x, hit_y, draw_start, draw_end, column_x_start, input ready);
    modport sink(input valid, ray_number, hit, side, cell_x, cell_y, ray_distance,
                 hit_x, hit_y, draw_start, draw_end, column_x_start, output ready);
endinterface

interface grc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/grc_div.sv =====
module grc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [grc_pkg::DIV_N_W-1:0]   i_dividend,
    input  logic [grc_pkg::DIV_D_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [grc_pkg::DIV_N_W-1:0]   o_quotient
);
    import grc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_dvs;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W:0]     n_trial;
    logic                 n_ge;

    always_comb begin
        n_trial = {r_rem, r_quo[DIV_N_W-1]};
        n_ge    = n_trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_ge ? DIV_D_W'(n_trial - {1'b0, r_dvs}) : n_trial[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], n_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ===== rtl/core/grc_ctrl.sv =====
module grc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  grc_pkg::t_stat i_stat,
    output grc_pkg::t_cmd  o_cmd,
    output logic           o_in_ready
);
    import grc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_stat.in_valid) n_state = ST_DIVX;
            ST_DIVX: n_state = ST_WDX;
            ST_WDX:  if (i_stat.div_done) n_state = ST_DIVY;
            ST_DIVY: n_state = ST_WDY;
            ST_WDY:  if (i_stat.div_done) n_state = ST_MULX;
            ST_MULX: n_state = ST_MULY;
            ST_MULY: n_state = ST_SETY;
            ST_SETY: n_state = ST_WALK;
            ST_WALK: if (i_stat.walk_done) n_state = ST_DIVH;
            ST_DIVH: n_state = ST_WDH;
            ST_WDH:  if (i_stat.div_done) n_state = ST_HITX;
            ST_HITX: n_state = ST_HITY;
            ST_HITY: n_state = ST_FIN;
            ST_FIN:  if (i_stat.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op        = OP_NONE;
        o_cmd.div_start = 1'b0;
        o_in_ready      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_stat.in_valid) o_cmd.op = OP_LOAD;
            end
            ST_DIVX: begin
                o_cmd.op        = OP_DIV_X;
                o_cmd.div_start = 1'b1;
            end
            ST_WDX:  if (i_stat.div_done) o_cmd.op = OP_LATCH_DX;
            ST_DIVY: begin
                o_cmd.op        = OP_DIV_Y;
                o_cmd.div_start = 1'b1;
            end
            ST_WDY:  if (i_stat.div_done) o_cmd.op = OP_LATCH_DY;
            ST_MULX: o_cmd.op = OP_MUL_LX;
            ST_MULY: o_cmd.op = OP_MUL_LY;
            ST_SETY: o_cmd.op = OP_SET_LY;
            ST_WALK: if (!i_stat.walk_done) o_cmd.op = OP_STEP;
            ST_DIVH: begin
                o_cmd.op        = OP_DIV_H;
                o_cmd.div_start = 1'b1;
            end
            ST_WDH:  if (i_stat.div_done) o_cmd.op = OP_LATCH_H;
            ST_HITX: o_cmd.op = OP_MUL_HX;
            ST_HITY: o_cmd.op = OP_MUL_HY;
            ST_FIN:  if (i_stat.out_free) o_cmd.op = OP_OUT;
            default: o_cmd.op = OP_NONE;
        endcase
    end
endmodule

// ===== rtl/core/grc_dp.sv =====
module grc_dp #(
    parameter int MAP_STRIDE = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  grc_pkg::t_cmd                  i_cmd,
    output grc_pkg::t_stat                 o_stat,
    input  logic                           i_in_valid,
    input  logic [17:0]                    i_pos_x,
    input  logic [17:0]                    i_pos_y,
    input  logic signed [15:0]             i_dir_x,
    input  logic signed [15:0]             i_dir_y,
    input  logic [7:0]                     i_ray_index,
    input  logic                           i_cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [7:0]                     o_ray_number,
    output logic                           o_hit,
    output logic                           o_side,
    output logic signed [8:0]              o_cell_x,
    output logic signed [8:0]              o_cell_y,
    output logic [23:0]                    o_ray_distance,
    output logic [17:0]                    o_hit_x,
    output logic [17:0]                    o_hit_y,
    output logic [10:0]                    o_draw_start,
    output logic [10:0]                    o_draw_end,
    output logic [15:0]                    o_column_x_start
);
    import grc_pkg::*;

    localparam int XCELLS = 64 / MAP_STRIDE;

    // configuration
    logic [63:0] r_map_bits;
    logic [3:0]  r_map_w;
    logic [3:0]  r_map_h;
    logic [3:0]  r_csl_cfg;
    logic [7:0]  r_max_dist;
    logic [10:0] r_win_h;
    logic [7:0]  r_col_w;

    // ray state
    logic [25:0]        r_sx;
    logic [25:0]        r_sy;
    logic signed [15:0] r_dx;
    logic signed [15:0] r_dy;
    logic [7:0]         r_ridx;
    logic [23:0]        r_ddx;
    logic [23:0]        r_ddy;
    logic [23:0]        r_lx;
    logic [23:0]        r_ly;
    logic signed [11:0] r_cx;
    logic signed [11:0] r_cy;
    logic [23:0]        r_dist;
    logic               r_found;
    logic               r_side;
    logic [41:0]        r_half;
    logic [10:0]        r_ds;
    logic [10:0]        r_de;
    logic [17:0]        r_hx;
    logic signed [42:0] r_prod;

    // output register
    logic               r_ov;
    logic [7:0]         r_o_ridx;
    logic               r_o_hit;
    logic               r_o_side;
    logic [8:0]         r_o_cx;
    logic [8:0]         r_o_cy;
    logic [23:0]        r_o_dist;
    logic [17:0]        r_o_hx;
    logic [17:0]        r_o_hy;
    logic [10:0]        r_o_ds;
    logic [10:0]        r_o_de;
    logic [15:0]        r_o_colx;

    logic [3:0]         n_csl;
    logic [16:0]        n_ax;
    logic [16:0]        n_ay;
    logic [16:0]        n_part_x;
    logic [16:0]        n_part_y;
    logic signed [17:0] n_ma;
    logic signed [24:0] n_mb;
    logic [DIV_N_W-1:0] n_dividend;
    logic [DIV_D_W-1:0] n_divisor;
    logic               n_div_done;
    logic [DIV_N_W-1:0] n_quo;
    logic [23:0]        n_quo_sat;
    logic               n_x_first;
    logic signed [11:0] n_cx;
    logic signed [11:0] n_cy;
    logic [24:0]        n_lx_sum;
    logic [24:0]        n_ly_sum;
    logic [6:0]         n_w_lim;
    logic [3:0]         n_h_lim;
    logic [11:0]        n_bit_idx;
    logic               n_occ;
    logic [23:0]        n_limit;
    logic [42:0]        n_mid;
    logic [42:0]        n_half;
    logic [42:0]        n_sum;
    logic [10:0]        n_ds;
    logic [10:0]        n_de;
    logic [26:0]        n_de_raw;

    function automatic logic [23:0] sat_q16(input logic signed [42:0] p);
        if (p[42:40] != 3'b000) return SAT24;
        return p[39:16];
    endfunction

    function automatic logic [17:0] hit_coord(input logic [25:0] s,
                                              input logic signed [42:0] p,
                                              input logic [3:0] csl);
        logic signed [42:0] total;
        logic [50:0]        shifted;
        total   = $signed({3'b000, s, 14'b0}) + p;
        shifted = 51'(total[41:0]) << csl;
        if (total[42]) return '0;
        if (shifted[50:22] > 29'(HIT_MAX)) return HIT_MAX;
        return shifted[39:22];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_bits <= '0;
            r_map_w    <= 4'd8;
            r_map_h    <= 4'd8;
            r_csl_cfg  <= 4'd6;
            r_max_dist <= 8'd100;
            r_win_h    <= 11'd480;
            r_col_w    <= 8'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAP_BITS:   r_map_bits <= i_cfg_data;
                CFG_MAP_WIDTH:  r_map_w    <= i_cfg_data[3:0];
                CFG_MAP_HEIGHT: r_map_h    <= i_cfg_data[3:0];
                CFG_CELL_LOG2:  r_csl_cfg  <= i_cfg_data[3:0];
                CFG_MAX_DIST:   r_max_dist <= i_cfg_data[7:0];
                CFG_WIN_H:      r_win_h    <= i_cfg_data[10:0];
                CFG_COL_W:      r_col_w    <= i_cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        n_csl    = (r_csl_cfg > 4'd8) ? 4'd8 : r_csl_cfg;
        n_ax     = r_dx[15] ? 17'd0 - {1'b1, r_dx} : {1'b0, r_dx};
        n_ay     = r_dy[15] ? 17'd0 - {1'b1, r_dy} : {1'b0, r_dy};
        n_part_x = r_dx[15] ? {1'b0, r_sx[15:0]} : 17'h10000 - {1'b0, r_sx[15:0]};
        n_part_y = r_dy[15] ? {1'b0, r_sy[15:0]} : 17'h10000 - {1'b0, r_sy[15:0]};
        n_limit  = {r_max_dist, 16'b0};
    end

    // shared divider operands
    always_comb begin
        case (i_cmd.op)
            OP_DIV_X: begin
                n_dividend = DIV_N_W'(1) << 30;
                n_divisor  = DIV_D_W'(n_ax);
            end
            OP_DIV_Y: begin
                n_dividend = DIV_N_W'(1) << 30;
                n_divisor  = DIV_D_W'(n_ay);
            end
            default: begin
                n_dividend = {r_win_h, 32'b0};
                n_divisor  = r_dist;
            end
        endcase
    end

    grc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (n_div_done),
        .o_quotient (n_quo)
    );

    assign n_quo_sat = (n_quo[42:24] != '0) ? SAT24 : n_quo[23:0];

    // shared multiplier operands
    always_comb begin
        case (i_cmd.op)
            OP_MUL_LX: begin
                n_ma = $signed({1'b0, n_part_x});
                n_mb = $signed({1'b0, r_ddx});
            end
            OP_MUL_LY: begin
                n_ma = $signed({1'b0, n_part_y});
                n_mb = $signed({1'b0, r_ddy});
            end
            OP_MUL_HX: begin
                n_ma = 18'(r_dx);
                n_mb = $signed({1'b0, r_dist});
            end
            default: begin
                n_ma = 18'(r_dy);
                n_mb = $signed({1'b0, r_dist});
            end
        endcase
    end

    // one DDA step: cross the nearer boundary, y on a tie
    always_comb begin
        n_x_first = r_lx < r_ly;
        n_cx      = r_cx;
        n_cy      = r_cy;
        if (n_x_first) begin
            n_cx = r_dx[15] ? r_cx - 12'sd1 : r_cx + 12'sd1;
        end else begin
            n_cy = r_dy[15] ? r_cy - 12'sd1 : r_cy + 12'sd1;
        end
        n_lx_sum  = {1'b0, r_lx} + {1'b0, r_ddx};
        n_ly_sum  = {1'b0, r_ly} + {1'b0, r_ddy};
        n_w_lim   = (7'(r_map_w) > 7'(XCELLS)) ? 7'(XCELLS) : 7'(r_map_w);
        n_h_lim   = (r_map_h > 4'(MAP_STRIDE)) ? 4'(MAP_STRIDE) : r_map_h;
        n_bit_idx = 12'(12'(n_cx) * 12'(MAP_STRIDE)) + 12'(n_cy);
        n_occ     = !n_cx[11] && !n_cy[11] && ($unsigned(n_cx) < 12'(n_w_lim)) &&
                    ($unsigned(n_cy) < 12'(n_h_lim)) && r_map_bits[n_bit_idx[5:0]];
    end

    // wall slice rows
    always_comb begin
        n_mid    = 43'({r_win_h[10:1], 16'b0});
        n_half   = {1'b0, r_half};
        n_sum    = n_mid + n_half;
        n_de_raw = n_sum[42:16];
        if (r_win_h == '0) begin
            n_ds = '0;
            n_de = '0;
        end else if (r_dist == '0) begin
            n_ds = '0;
            n_de = r_win_h - 11'd1;
        end else begin
            n_ds = (n_half >= n_mid) ? '0 : 11'((n_mid - n_half) >> 16);
            n_de = (n_de_raw >= 27'(r_win_h)) ? r_win_h - 11'd1 : n_de_raw[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_sx    <= 26'({i_pos_x, 8'b0} >> n_csl);
                r_sy    <= 26'({i_pos_y, 8'b0} >> n_csl);
                r_dx    <= i_dir_x;
                r_dy    <= i_dir_y;
                r_ridx  <= i_ray_index;
                r_cx    <= $signed({2'b00, 10'(({i_pos_x, 8'b0} >> n_csl) >> 16)});
                r_cy    <= $signed({2'b00, 10'(({i_pos_y, 8'b0} >> n_csl) >> 16)});
                r_dist  <= '0;
                r_found <= 1'b0;
                r_side  <= 1'b0;
            end
            OP_LATCH_DX: r_ddx <= (n_ax == '0) ? SAT24 : n_quo_sat;
            OP_LATCH_DY: r_ddy <= (n_ay == '0) ? SAT24 : n_quo_sat;
            OP_MUL_LX:   r_prod <= n_ma * n_mb;
            OP_MUL_LY: begin
                r_lx   <= sat_q16(r_prod);
                r_prod <= n_ma * n_mb;
            end
            OP_SET_LY:   r_ly <= sat_q16(r_prod);
            OP_STEP: begin
                r_cx    <= n_cx;
                r_cy    <= n_cy;
                r_found <= n_occ;
                if (n_x_first) begin
                    r_dist <= r_lx;
                    r_lx   <= n_lx_sum[24] ? SAT24 : n_lx_sum[23:0];
                    r_side <= 1'b0;
                end else begin
                    r_dist <= r_ly;
                    r_ly   <= n_ly_sum[24] ? SAT24 : n_ly_sum[23:0];
                    r_side <= 1'b1;
                end
            end
            OP_LATCH_H:  r_half <= n_quo[42:1];
            OP_MUL_HX: begin
                r_prod <= n_ma * n_mb;
                r_ds   <= n_ds;
                r_de   <= n_de;
            end
            OP_MUL_HY: begin
                r_hx   <= r_found ? hit_coord(r_sx, r_prod, n_csl) : '0;
                r_prod <= n_ma * n_mb;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_o_ridx <= r_ridx;
            r_o_hit  <= r_found;
            r_o_side <= r_side;
            r_o_cx   <= r_cx[8:0];
            r_o_cy   <= r_cy[8:0];
            r_o_dist <= r_dist;
            r_o_hx   <= r_hx;
            r_o_hy   <= r_found ? hit_coord(r_sy, r_prod, n_csl) : '0;
            r_o_ds   <= r_ds;
            r_o_de   <= r_de;
            r_o_colx <= r_ridx * r_col_w;
        end
    end

    assign o_stat.in_valid  = i_in_valid;
    assign o_stat.div_done  = n_div_done;
    assign o_stat.walk_done = r_found || (r_dist >= n_limit);
    assign o_stat.out_free  = !r_ov || i_out_ready;

    assign o_out_valid      = r_ov;
    assign o_ray_number     = r_o_ridx;
    assign o_hit            = r_o_hit;
    assign o_side           = r_o_side;
    assign o_cell_x         = $signed(r_o_cx);
    assign o_cell_y         = $signed(r_o_cy);
    assign o_ray_distance   = r_o_dist;
    assign o_hit_x          = r_o_hx;
    assign o_hit_y          = r_o_hy;
    assign o_draw_start     = r_o_ds;
    assign o_draw_end       = r_o_de;
    assign o_column_x_start = r_o_colx;
endmodule

// ===== rtl/core/grid_ray_caster_unit.sv =====
// channel  dir  modport  carries
// i_ray    in   sink     pos_x, pos_y, dir_x, dir_y, ray_index
// o_res    out  source   ray_number .. column_x_start, one per ray
// i_cfg    in   sink     index, data (register write)
//
// A ray goes from request to result through three passes of the restoring divider
// and the DDA walk, which takes one step per cycle.
// i_rst_n is synchronous, active low; configuration registers return to reset values.
// A new ray is taken while the previous result waits in the output register.
// A stalled result holds the unit in its last state until taken.
module grid_ray_caster_unit #(
    parameter int MAP_STRIDE = 8
) (
    input logic  i_clk,
    input logic  i_rst_n,
    grc_ray_if.sink   i_ray,
    grc_res_if.source o_res,
    grc_cfg_if.sink   i_cfg
);
    import grc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign i_cfg.ready = 1'b1;

    grc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (i_ray.ready)
    );

    grc_dp #(
        .MAP_STRIDE (MAP_STRIDE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_in_valid       (i_ray.valid),
        .i_pos_x          (i_ray.pos_x),
        .i_pos_y          (i_ray.pos_y),
        .i_dir_x          (i_ray.dir_x),
        .i_dir_y          (i_ray.dir_y),
        .i_ray_index      (i_ray.ray_index),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_ray_number     (o_res.ray_number),
        .o_hit            (o_res.hit),
        .o_side           (o_res.side),
        .o_cell_x         (o_res.cell_x),
        .o_cell_y         (o_res.cell_y),
        .o_ray_distance   (o_res.ray_distance),
        .o_hit_x          (o_res.hit_x),
        .o_hit_y          (o_res.hit_y),
        .o_draw_start     (o_res.draw_start),
        .o_draw_end       (o_res.draw_end),
        .o_column_x_start (o_res.column_x_start)
    );
endmodule

// ===== rtl/core/grc_checker.sv =====
module grc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_ray_number,
    input logic        i_hit,
    input logic [17:0] i_hit_x,
    input logic [17:0] i_hit_y,
    input logic [10:0] i_draw_start,
    input logic [10:0] i_draw_end
);
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_ray_number))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hit |-> i_hit_x == 18'd0 && i_hit_y == 18'd0)
        else $error("hit point set without a hit");

    a_slice_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_draw_start <= i_draw_end)
        else $error("slice top below bottom");
endmodule

bind grid_ray_caster_unit grc_checker u_grc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_ray_number (o_res.ray_number),
    .i_hit        (o_res.hit),
    .i_hit_x      (o_res.hit_x),
    .i_hit_y      (o_res.hit_y),
    .i_draw_start (o_res.draw_start),
    .i_draw_end   (o_res.draw_end)
);
